FILE: rtl/lge_pkg.sv
// ============================================================================
// lge_pkg
// Shared widths, codes, reset values and controller/datapath structs for the
// life grid engine.
// ============================================================================
package lge_pkg;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int OP_W      = 2;
    localparam int COORD_W   = 6;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 7'd64;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd64;

    // operation codes (any other code reads)
    localparam logic [OP_W-1:0] OP_SET     = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;

    // controller -> datapath
    typedef struct packed {
        logic take;         // latch the accepted transaction
        logic clear_step;   // write one zero row of the clearing pass
        logic sweep_step;   // one row step of a generation sweep
        logic cell_read;    // read the row of the addressed cell
        logic cell_modify;  // update addressed row, form the result
        logic out_load;     // move the result into the output register
    } lge_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic sweep_last;
    } lge_stat_t;

endpackage

FILE: rtl/lge_req_if.sv
// ============================================================================
// lge_req_if
// Request channel: operation and cell coordinate, valid/ready handshake.
// ============================================================================
interface lge_req_if import lge_pkg::*;;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;

    modport source (output valid, output op, output cell_x, output cell_y, input ready);
    modport sink   (input valid, input op, input cell_x, input cell_y, output ready);
endinterface

FILE: rtl/lge_rsp_if.sv
// ============================================================================
// lge_rsp_if
// Response channel: addressed cell state and range flag, valid/ready handshake.
// ============================================================================
interface lge_rsp_if;
    logic valid;
    logic ready;
    logic alive;
    logic out_of_range;

    modport source (output valid, output alive, output out_of_range, input ready);
    modport sink   (input valid, input alive, input out_of_range, output ready);
endinterface

FILE: rtl/lge_ctrl.sv
// ============================================================================
// lge_ctrl
// Sequencer: clearing pass, generation sweep, cell access, result handoff.
// ============================================================================
module lge_ctrl import lge_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_advance,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output lge_cmd_t  cmd,
    input  lge_stat_t stat
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SWEEP  = 6'b000100,
        ST_READ   = 6'b001000,
        ST_MODIFY = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = in_advance ? ST_SWEEP : ST_READ;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.cell_read = 1'b1;
                state_next    = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                cmd.cell_modify = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/lge_datapath.sv
// ============================================================================
// lge_datapath
// Row-wide cell memory, three-row window, B3/S23 row update, config regs.
// ============================================================================
module lge_datapath import lge_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  lge_cmd_t             cmd,
    output lge_stat_t            stat,
    input  logic [OP_W-1:0]      op,
    input  logic [COORD_W-1:0]   cell_x,
    input  logic [COORD_W-1:0]   cell_y,
    output logic                 alive,
    output logic                 out_of_range
);

    localparam int ROW_AW = $clog2(MAX_HEIGHT);
    localparam int CNT_W  = $clog2(MAX_HEIGHT + 2);
    localparam int W_A    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int W_B    = ($clog2(MAX_WIDTH + 1) > COORD_W) ? $clog2(MAX_WIDTH + 1) : COORD_W;
    localparam int W_C    = ($clog2(MAX_HEIGHT + 1) > W_B) ? $clog2(MAX_HEIGHT + 1) : W_B;
    localparam int CMP_W  = ((W_A > W_C) ? W_A : W_C) + 1;

    localparam logic [CNT_W-1:0] CLEAR_LAST = CNT_W'(MAX_HEIGHT - 1);
    localparam logic [CNT_W-1:0] SWEEP_LAST = CNT_W'(MAX_HEIGHT + 1);
    localparam logic [CMP_W-1:0] MAXW_C     = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] MAXH_C     = CMP_W'(MAX_HEIGHT);

    logic [CFG_W-1:0]     grid_width_reg, grid_height_reg;
    logic [OP_W-1:0]      op_reg;
    logic [COORD_W-1:0]   x_reg, y_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [MAX_WIDTH-1:0] top_reg, mid_reg, rdata_reg;
    logic                 pend_alive_reg, pend_oor_reg;
    logic                 alive_reg, oor_reg;

    logic [MAX_WIDTH-1:0] row_mem [MAX_HEIGHT];

    logic [CMP_W-1:0]     gw_c, gh_c;
    logic [MAX_WIDTH-1:0] col_mask, set_mask, bottom, new_row, mod_row;
    logic [CNT_W-1:0]     btm_idx, nrow_idx;
    logic                 btm_ok, nrow_ok, in_grid, cell_bit, is_set, cnt_in_mem;
    logic                 mem_we, mem_re;
    logic [ROW_AW-1:0]    mem_waddr, mem_raddr, y_row;
    logic [MAX_WIDTH-1:0] mem_wdata;

    assign gw_c   = CMP_W'(grid_width_reg);
    assign gh_c   = CMP_W'(grid_height_reg);
    assign is_set = (op_reg == OP_SET);
    assign y_row  = ROW_AW'(y_reg);

    assign in_grid = (CMP_W'(x_reg) < gw_c) && (CMP_W'(x_reg) < MAXW_C) &&
                     (CMP_W'(y_reg) < gh_c) && (CMP_W'(y_reg) < MAXH_C);

    always_comb
    begin
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            col_mask[c] = (CMP_W'(c) < gw_c);
            set_mask[c] = (CMP_W'(c) == CMP_W'(x_reg));
        end
    end

    assign cell_bit = |(rdata_reg & set_mask);
    assign mod_row  = rdata_reg | set_mask;

    // window: top = row cnt-3, mid = row cnt-2, bottom = row cnt-1
    assign btm_idx    = cnt_reg - CNT_W'(1);
    assign nrow_idx   = cnt_reg - CNT_W'(2);
    assign btm_ok     = (cnt_reg != '0) && (CMP_W'(btm_idx) < MAXH_C) &&
                        (CMP_W'(btm_idx) < gh_c);
    assign nrow_ok    = (CMP_W'(nrow_idx) < gh_c);
    assign bottom     = btm_ok ? (rdata_reg & col_mask) : '0;
    assign cnt_in_mem = (CMP_W'(cnt_reg) < MAXH_C);

    always_comb
    begin : next_row_calc
        logic [MAX_WIDTH+1:0] tp, mp, bp;
        logic [3:0]           nb;
        tp = {1'b0, top_reg, 1'b0};
        mp = {1'b0, mid_reg, 1'b0};
        bp = {1'b0, bottom, 1'b0};
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            nb = 4'(tp[c]) + 4'(tp[c+1]) + 4'(tp[c+2]) +
                 4'(mp[c]) + 4'(mp[c+2]) +
                 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
            new_row[c] = col_mask[c] & nrow_ok &
                         ((nb == 4'd3) | (mid_reg[c] & (nb == 4'd2)));
        end
    end

    // memory port steering
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[ROW_AW-1:0];
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = cnt_reg[ROW_AW-1:0];
        if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        if (cmd.sweep_step)
        begin
            mem_we    = (cnt_reg >= CNT_W'(2));
            mem_waddr = nrow_idx[ROW_AW-1:0];
            mem_wdata = new_row;
            mem_re    = cnt_in_mem;
        end
        if (cmd.cell_read)
        begin
            mem_re    = in_grid;
            mem_raddr = y_row;
        end
        if (cmd.cell_modify)
        begin
            mem_we    = is_set && in_grid;
            mem_waddr = y_row;
            mem_wdata = mod_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= row_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg  <= op;
            x_reg   <= cell_x;
            y_reg   <= cell_y;
            top_reg <= '0;
            mid_reg <= '0;
        end
        if (cmd.sweep_step)
        begin
            top_reg <= mid_reg;
            mid_reg <= bottom;
        end
        if (cmd.cell_modify)
        begin
            pend_alive_reg <= in_grid & (is_set | cell_bit);
            pend_oor_reg   <= !in_grid;
        end
        if (cmd.out_load)
        begin
            alive_reg <= pend_alive_reg;
            oor_reg   <= pend_oor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            cnt_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                    CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                    default:         grid_width_reg  <= grid_width_reg;
                endcase
            end
            if (cmd.take)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.clear_step || cmd.sweep_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    assign stat.clear_last = (cnt_reg == CLEAR_LAST);
    assign stat.sweep_last = (cnt_reg == SWEEP_LAST);
    assign alive           = alive_reg;
    assign out_of_range    = oor_reg;

endmodule

FILE: rtl/life_grid_engine_core.sv
// ============================================================================
// life_grid_engine_core
// Bounded B3/S23 life grid with set, advance and read requests.
// ============================================================================
// The grid lives in a row-wide memory (MAX_HEIGHT rows of MAX_WIDTH bits).
// After reset a clearing pass writes every row to dead, one row per cycle,
// and req.ready stays low until the pass ends; configuration writes are
// taken throughout. A set or read goes through row read, read-modify-write
// and output load (the request is latched at the accepting edge); rsp.valid
// rises and req.ready returns in the same cycle, once the output load is
// done. An advance first runs a sweep that streams one row per cycle
// through a three-row window (MAX_HEIGHT + 2 steps) and writes each new row
// back in place two rows behind the read pointer, with all columns of a row
// updated at once; the single memory read port sets that rate. After the
// sweep the addressed cell is read and reported as it stands in the new
// generation. Results go through an output register, so the next
// transaction is accepted while a result still waits on rsp.ready; the
// output load of that next one then waits as long as rsp.ready stays low.
// Cells outside the configured grid_width x grid_height count as dead; a
// set there is dropped and the response flags out_of_range.
// ============================================================================
module life_grid_engine_core import lge_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    lge_req_if.sink              req,
    lge_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    lge_cmd_t  ctl_cmd;
    lge_stat_t ctl_stat;

    // sequencer: owns both handshakes and the phase of each transaction
    lge_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_advance (req.op == OP_ADVANCE),
        .in_ready   (req.ready),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .cmd        (ctl_cmd),
        .stat       (ctl_stat)
    );

    // memory, row update logic, config registers and result registers
    lge_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (ctl_cmd),
        .stat         (ctl_stat),
        .op           (req.op),
        .cell_x       (req.cell_x),
        .cell_y       (req.cell_y),
        .alive        (rsp.alive),
        .out_of_range (rsp.out_of_range)
    );

endmodule
